@@ rtl/core/mf3_pkg.sv @@
// Shared types, constants and helper functions for the 3x3 median filter.
// Used by every module of the filter; depends on nothing else.
`timescale 1ns / 1ps

package mf3_pkg;

	localparam int PIX_W      = 8;
	localparam int CFGW_W     = 11;
	localparam int CFGH_W     = 12;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int ROW_W      = 13;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	localparam logic [CFGW_W-1:0] WIDTH_RST  = 11'd1024;
	localparam logic [CFGH_W-1:0] HEIGHT_RST = 12'd1024;

	// Output queue in front of the result port
	localparam int OQ_DEPTH = 8;
	localparam int OQ_AW    = 3;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		pix_t pixel;
		logic flush;
	} pix_in_t;

	typedef struct packed {
		pix_t median;
		logic end_of_frame;
	} pix_out_t;

	// One window column; raw order p0 = top, p2 = bottom, sorted order p0 = min
	typedef struct packed {
		pix_t p2;
		pix_t p1;
		pix_t p0;
	} pix3_t;

	typedef struct packed {
		logic top_off;
		logic bot_off;
		logic col_off;
	} cell_mask_t;

	typedef struct packed {
		logic top_off;
		logic bot_off;
		logic left_off;
		logic right_off;
	} win_mask_t;

	function automatic pix3_t sort3(pix3_t v);
		pix_t a;
		pix_t b;
		pix_t c;
		pix_t t;
		pix3_t r;
		a = v.p0;
		b = v.p1;
		c = v.p2;
		if (a > b) begin
			t = a;
			a = b;
			b = t;
		end
		if (b > c) begin
			t = b;
			b = c;
			c = t;
		end
		if (a > b) begin
			t = a;
			a = b;
			b = t;
		end
		r.p0 = a;
		r.p1 = b;
		r.p2 = c;
		return r;
	endfunction

endpackage

@@ rtl/core/mf3_line.sv @@
// Line memory holding the two previous image rows, one entry per column.
// Depends on mf3_pkg for the pixel width.
`timescale 1ns / 1ps

module mf3_line #(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [2*mf3_pkg::PIX_W-1:0] rd_data,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [2*mf3_pkg::PIX_W-1:0] wr_data
);

	logic [2*mf3_pkg::PIX_W-1:0] mem [DEPTH];
	logic [2*mf3_pkg::PIX_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			// forward a write that lands on the same column in this cycle
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/core/mf3_cell.sv @@
// One column cell of the 3x3 window: holds three pixels, hands them on to
// its older neighbor, and presents its column masked and sorted. Uses mf3_pkg.
`timescale 1ns / 1ps

module mf3_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift,
	input  mf3_pkg::pix3_t      din,
	input  mf3_pkg::cell_mask_t mask,
	output mf3_pkg::pix3_t      col,
	output mf3_pkg::pix3_t      srt
);

	mf3_pkg::pix3_t col_q;
	mf3_pkg::pix3_t msk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= din;
		end
	end

	// zero the pixels that fall outside the frame
	always_comb begin
		msk = col_q;
		if (mask.top_off) begin
			msk.p0 = '0;
		end
		if (mask.bot_off) begin
			msk.p2 = '0;
		end
		if (mask.col_off) begin
			msk = '0;
		end
	end

	assign col = col_q;
	assign srt = mf3_pkg::sort3(msk);

endmodule

@@ rtl/core/mf3_med.sv @@
// Two-stage median-of-nine network fed with three sorted window columns.
// Uses mf3_pkg for the pixel types and the three-input sort.
`timescale 1ns / 1ps

module mf3_med (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_eof,
	input  mf3_pkg::pix3_t    srt0,
	input  mf3_pkg::pix3_t    srt1,
	input  mf3_pkg::pix3_t    srt2,
	output logic              res_valid,
	output mf3_pkg::pix_out_t res,
	output logic [1:0]        pend
);

	logic           v_s3;
	logic           eof_s3;
	mf3_pkg::pix3_t c0_s3;
	mf3_pkg::pix3_t c1_s3;
	mf3_pkg::pix3_t c2_s3;
	logic           v_s4;
	logic           eof_s4;
	mf3_pkg::pix3_t tri_s4;
	mf3_pkg::pix3_t mins;
	mf3_pkg::pix3_t mids;
	mf3_pkg::pix3_t maxs;
	mf3_pkg::pix3_t mins_srt;
	mf3_pkg::pix3_t mids_srt;
	mf3_pkg::pix3_t maxs_srt;
	mf3_pkg::pix3_t tri_d;
	mf3_pkg::pix3_t tri_srt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s3 <= in_valid;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		eof_s3 <= in_eof;
		c0_s3  <= srt0;
		c1_s3  <= srt1;
		c2_s3  <= srt2;
		eof_s4 <= eof_s3;
		tri_s4 <= tri_d;
	end

	// largest minimum, middle median, smallest maximum
	always_comb begin
		mins     = {c2_s3.p0, c1_s3.p0, c0_s3.p0};
		mids     = {c2_s3.p1, c1_s3.p1, c0_s3.p1};
		maxs     = {c2_s3.p2, c1_s3.p2, c0_s3.p2};
		mins_srt = mf3_pkg::sort3(mins);
		mids_srt = mf3_pkg::sort3(mids);
		maxs_srt = mf3_pkg::sort3(maxs);
		tri_d.p0 = mins_srt.p2;
		tri_d.p1 = mids_srt.p1;
		tri_d.p2 = maxs_srt.p0;
	end

	assign tri_srt          = mf3_pkg::sort3(tri_s4);
	assign res_valid        = v_s4;
	assign res.median       = tri_srt.p1;
	assign res.end_of_frame = eof_s4;
	assign pend             = {1'b0, v_s3} + {1'b0, v_s4};

endmodule

@@ rtl/core/median_filter_3x3_top.sv @@
// Top level of the streaming 3x3 median filter: counters, setup sequencer,
// window cell chain, median network and output queue. Uses mf3_pkg, mf3_line,
// mf3_cell and mf3_med.
`timescale 1ns / 1ps

// The filter takes one pixel item per clock while not stalled and gives at most
// one result per item. The result for a pixel leaves on the item that arrives
// one row plus one pixel later, through an eight-entry output queue; outside
// setup, input stalls only when that queue could overflow. Pixels outside the
// frame count as zero; after the last pixel, flush items push out the remaining
// results and the last one carries end_of_frame. After reset and after every
// register write the input stalls while the setup sequencer loads the width and
// height, forms the frame size and start position, and a one-bit-per-clock
// divider splits the output count into row and column for the new width.
// The line memory is MAX_WIDTH x 16 bits with one read and one write a clock.
module median_filter_3x3_top #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  mf3_pkg::pix_in_t                  in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output mf3_pkg::pix_out_t                 out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mf3_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mf3_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CB  = $clog2(MAX_WIDTH);
	localparam int WB  = $clog2(MAX_WIDTH + 1);
	localparam int HB  = mf3_pkg::CFGH_W;
	localparam int RB  = mf3_pkg::ROW_W;
	localparam int TB  = WB + HB;
	localparam int PB  = WB + RB;
	localparam int DCB = $clog2(TB + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_POS,
		ST_DIV
	} state_t;

	state_t state_q;

	logic [mf3_pkg::CFGW_W-1:0] width_q;
	logic [mf3_pkg::CFGH_W-1:0] height_q;
	logic                       cfg_we;

	logic [WB-1:0]  we_q;
	logic [HB-1:0]  he_q;
	logic [TB-1:0]  total_q;
	logic [CB-1:0]  col_q;
	logic [RB-1:0]  row_q;
	logic [TB-1:0]  cnt_q;
	logic [PB-1:0]  pos_q;
	logic [CB-1:0]  ocol_q;
	logic [HB-1:0]  orow_q;
	logic           col_clr_q;
	logic           frm_clr_q;
	logic [PB-1:0]  prod_q;
	logic [WB-1:0]  div_rem_q;
	logic [TB-1:0]  div_quo_q;
	logic [DCB-1:0] div_n_q;

	logic [WB:0]    rem_sh;
	logic [WB:0]    rem_dif;
	logic           rem_ge;
	logic [WB-1:0]  rem_nx;
	logic [TB-1:0]  quo_nx;
	logic           frm_d;

	logic                 acc;
	logic [CB-1:0]        col_e;
	logic [RB-1:0]        row_e;
	logic [TB-1:0]        cnt_e;
	logic                 in_frame;
	logic                 ign;
	mf3_pkg::pix_t        val;
	logic                 emit;
	logic                 eof;
	logic [CB:0]          col_inc;
	logic                 wrap;
	logic [CB:0]          ocol_inc;
	logic                 owrap;
	mf3_pkg::win_mask_t   mask;

	logic                 act_s1;
	logic                 emit_s1;
	logic                 eof_s1;
	mf3_pkg::win_mask_t   mask_s1;
	mf3_pkg::pix_t        val_s1;
	logic [CB-1:0]        addr_s1;
	logic                 emit_s2;
	logic                 eof_s2;
	mf3_pkg::win_mask_t   mask_s2;

	logic [2*mf3_pkg::PIX_W-1:0] rd_data;
	mf3_pkg::pix3_t       din2;
	mf3_pkg::pix3_t       col0;
	mf3_pkg::pix3_t       col1;
	mf3_pkg::pix3_t       col2;
	mf3_pkg::pix3_t       srt0;
	mf3_pkg::pix3_t       srt1;
	mf3_pkg::pix3_t       srt2;
	mf3_pkg::cell_mask_t  cmask0;
	mf3_pkg::cell_mask_t  cmask1;
	mf3_pkg::cell_mask_t  cmask2;

	logic                 med_valid;
	mf3_pkg::pix_out_t    med_res;
	logic [1:0]           med_pend;

	mf3_pkg::pix_out_t          oq_mem [mf3_pkg::OQ_DEPTH];
	logic [mf3_pkg::OQ_AW-1:0]  oq_wr_q;
	logic [mf3_pkg::OQ_AW-1:0]  oq_rd_q;
	logic [mf3_pkg::OQ_AW:0]    oq_cnt_q;
	logic                       pop;
	logic [31:0]                credit;

	// ---------------- configuration registers ----------------

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mf3_pkg::WIDTH_RST;
			height_q <= mf3_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mf3_pkg::REG_IMAGE_WIDTH: begin
					width_q <= cfg_data[mf3_pkg::CFGW_W-1:0];
				end
				mf3_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= cfg_data[mf3_pkg::CFGH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------- per-item control ----------------

	assign acc = in_valid && !in_stall;

	always_comb begin
		col_e    = (col_clr_q || frm_clr_q) ? '0 : col_q;
		row_e    = frm_clr_q ? '0 : row_q;
		cnt_e    = frm_clr_q ? '0 : cnt_q;
		in_frame = pos_q < PB'(total_q);
		ign      = in_frame && in_data.flush;
		val      = in_frame ? in_data.pixel : '0;
		emit     = pos_q >= (PB'(we_q) + PB'(1));
		eof      = (cnt_e + TB'(1)) == total_q;
		col_inc  = {1'b0, col_e} + (CB + 1)'(1);
		wrap     = 32'(col_inc) >= 32'(we_q);
		ocol_inc = {1'b0, ocol_q} + (CB + 1)'(1);
		owrap    = 32'(ocol_inc) >= 32'(we_q);

		mask.top_off   = orow_q == '0;
		mask.bot_off   = (32'(orow_q) + 32'd1) >= 32'(he_q);
		mask.left_off  = ocol_q == '0;
		mask.right_off = owrap;
	end

	// restoring divider step: output count into row and column
	always_comb begin
		rem_sh  = {div_rem_q, div_quo_q[TB-1]};
		rem_ge  = rem_sh >= {1'b0, we_q};
		rem_dif = rem_sh - {1'b0, we_q};
		rem_nx  = rem_ge ? rem_dif[WB-1:0] : rem_sh[WB-1:0];
		quo_nx  = {div_quo_q[TB-2:0], rem_ge};
		frm_d   = cnt_q >= total_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			we_q      <= '0;
			he_q      <= '0;
			total_q   <= '0;
			col_q     <= '0;
			row_q     <= '0;
			cnt_q     <= '0;
			pos_q     <= '0;
			ocol_q    <= '0;
			orow_q    <= '0;
			col_clr_q <= 1'b0;
			frm_clr_q <= 1'b0;
			prod_q    <= '0;
			div_rem_q <= '0;
			div_quo_q <= '0;
			div_n_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						col_clr_q <= 1'b0;
						frm_clr_q <= 1'b0;
						if (ign) begin
							// ignored flush: only commit the pending restarts
							col_q <= col_e;
							row_q <= row_e;
							cnt_q <= cnt_e;
						end else if (emit && eof) begin
							col_q  <= '0;
							row_q  <= '0;
							cnt_q  <= '0;
							pos_q  <= '0;
							ocol_q <= '0;
							orow_q <= '0;
						end else begin
							if (wrap) begin
								col_q <= '0;
								row_q <= row_e + RB'(1);
							end else begin
								col_q <= col_inc[CB-1:0];
								row_q <= row_e;
							end
							pos_q <= pos_q + PB'(1);
							if (emit) begin
								cnt_q <= cnt_e + TB'(1);
								if (owrap) begin
									ocol_q <= '0;
									orow_q <= orow_q + HB'(1);
								end else begin
									ocol_q <= ocol_inc[CB-1:0];
								end
							end else begin
								cnt_q <= cnt_e;
							end
						end
					end
				end
				ST_LOAD: begin
					if (width_q == '0) begin
						we_q <= WB'(1);
					end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
						we_q <= WB'(MAX_WIDTH);
					end else begin
						we_q <= WB'(width_q);
					end
					he_q    <= (height_q == '0) ? HB'(1) : height_q;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					total_q   <= TB'(we_q) * TB'(he_q);
					prod_q    <= PB'(row_q) * PB'(we_q);
					col_clr_q <= 32'(col_q) >= 32'(we_q);
					state_q   <= ST_POS;
				end
				ST_POS: begin
					frm_clr_q <= frm_d;
					if (frm_d) begin
						pos_q <= '0;
					end else begin
						pos_q <= prod_q + PB'(col_clr_q ? '0 : col_q);
					end
					div_rem_q <= '0;
					div_quo_q <= cnt_q;
					div_n_q   <= DCB'(TB);
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					div_rem_q <= rem_nx;
					div_quo_q <= quo_nx;
					div_n_q   <= div_n_q - DCB'(1);
					if (div_n_q == DCB'(1)) begin
						ocol_q  <= frm_clr_q ? '0 : CB'(rem_nx);
						orow_q  <= frm_clr_q ? '0 : quo_nx[HB-1:0];
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
			// a register write restarts the setup sequence
			if (cfg_we) begin
				state_q <= ST_LOAD;
			end
		end
	end

	// ---------------- stage 1 and 2 ----------------

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1  <= 1'b0;
			emit_s1 <= 1'b0;
			emit_s2 <= 1'b0;
		end else begin
			act_s1  <= acc && !ign;
			emit_s1 <= acc && !ign && emit;
			emit_s2 <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		eof_s1  <= eof && emit;
		mask_s1 <= mask;
		val_s1  <= val;
		addr_s1 <= col_e;
		eof_s2  <= eof_s1;
		mask_s2 <= mask_s1;
	end

	mf3_line #(
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk     (clk),
		.rd_en   (acc && !ign),
		.rd_addr (col_e),
		.rd_data (rd_data),
		.wr_en   (act_s1),
		.wr_addr (addr_s1),
		.wr_data ({rd_data[mf3_pkg::PIX_W-1:0], val_s1})
	);

	// ---------------- window cell chain ----------------

	always_comb begin
		din2.p0 = rd_data[2*mf3_pkg::PIX_W-1:mf3_pkg::PIX_W];
		din2.p1 = rd_data[mf3_pkg::PIX_W-1:0];
		din2.p2 = val_s1;

		cmask0.top_off = mask_s2.top_off;
		cmask0.bot_off = mask_s2.bot_off;
		cmask0.col_off = mask_s2.left_off;
		cmask1.top_off = mask_s2.top_off;
		cmask1.bot_off = mask_s2.bot_off;
		cmask1.col_off = 1'b0;
		cmask2.top_off = mask_s2.top_off;
		cmask2.bot_off = mask_s2.bot_off;
		cmask2.col_off = mask_s2.right_off;
	end

	mf3_cell u_cell2 (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (act_s1),
		.din    (din2),
		.mask   (cmask2),
		.col    (col2),
		.srt    (srt2)
	);

	mf3_cell u_cell1 (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (act_s1),
		.din    (col2),
		.mask   (cmask1),
		.col    (col1),
		.srt    (srt1)
	);

	mf3_cell u_cell0 (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (act_s1),
		.din    (col1),
		.mask   (cmask0),
		.col    (col0),
		.srt    (srt0)
	);

	mf3_med u_med (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (emit_s2),
		.in_eof    (eof_s2),
		.srt0      (srt0),
		.srt1      (srt1),
		.srt2      (srt2),
		.res_valid (med_valid),
		.res       (med_res),
		.pend      (med_pend)
	);

	// ---------------- output queue ----------------

	assign pop       = out_valid && !out_stall;
	assign out_valid = oq_cnt_q != '0;
	assign out_data  = oq_mem[oq_rd_q];

	always_ff @(posedge clk) begin
		if (med_valid) begin
			oq_mem[oq_wr_q] <= med_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (med_valid) begin
				oq_wr_q <= oq_wr_q + mf3_pkg::OQ_AW'(1);
			end
			if (pop) begin
				oq_rd_q <= oq_rd_q + mf3_pkg::OQ_AW'(1);
			end
			if (med_valid && !pop) begin
				oq_cnt_q <= oq_cnt_q + (mf3_pkg::OQ_AW + 1)'(1);
			end else if (!med_valid && pop) begin
				oq_cnt_q <= oq_cnt_q - (mf3_pkg::OQ_AW + 1)'(1);
			end
		end
	end

	// hold input while setting up or while results in flight could fill the queue
	assign credit   = 32'(oq_cnt_q) + 32'(emit_s1) + 32'(emit_s2) + 32'(med_pend);
	assign in_stall = (state_q != ST_IDLE) || (credit >= 32'(mf3_pkg::OQ_DEPTH));

	// ---------------- assertions ----------------

	a_oq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(med_valid && !pop) |-> (32'(oq_cnt_q) < 32'(mf3_pkg::OQ_DEPTH)))
		else $error("output queue overflow");

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit <= 32'(mf3_pkg::OQ_DEPTH))
		else $error("items in flight exceed queue space");

	a_eof_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !ign && emit && eof && !cfg_we) |=> (cnt_q == '0 && pos_q == '0))
		else $error("frame counters not restarted after last result");

	a_cnt_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !frm_clr_q) |-> (cnt_q < total_q))
		else $error("output count beyond frame size");

	a_ocol_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (32'(ocol_q) < 32'(we_q)))
		else $error("output column beyond row width");

endmodule
